// ----- sv/cvno_pkg.sv -----
// Package for the cloud value noise block: field widths, register indexes,
// reset values, arithmetic constants and the sequencer state type.
// No dependencies; every other file of the block uses it.
`timescale 1ns / 1ps

package cvno_pkg;

    // Field widths of the channels
    localparam int FUNC_W  = 1;
    localparam int SEL_W   = 2;
    localparam int COORD_W = 16;
    localparam int TEXEL_W = 8;
    localparam int VALUE_W = 8;

    // Operation codes carried in func
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 1'b1;

    // Configuration registers
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_OFFSET    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FLOOR     = 2'd2;
    localparam logic [CFG_W-1:0] OFFSET_RST    = 9'd20;
    localparam logic [CFG_W-1:0] THRESHOLD_RST = 9'd270;
    localparam logic [CFG_W-1:0] FLOOR_RST     = 9'd200;

    // Octave grid geometry: square grids of OCT_SIZE texels per side
    localparam int OCT_SIZE  = 32;
    localparam int TEX_IDX_W = $clog2(OCT_SIZE);

    // Octave sum and thin-cloud shaping
    localparam int SUM_W      = 9;
    localparam int PROD_W     = 2 * SUM_W;
    localparam int THIN_DIV   = 50;
    localparam int THIN_SHIFT = 24;
    localparam int RECIP_W    = 19;
    localparam logic [RECIP_W-1:0] THIN_RECIP =
        RECIP_W'(((1 << THIN_SHIFT) + THIN_DIV - 1) / THIN_DIV);
    localparam int QUO_W      = PROD_W + RECIP_W - THIN_SHIFT;
    localparam logic [VALUE_W-1:0] SAT_MAX = 8'd255;

    // Query sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_OFFS,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } cvno_state_t;

endpackage

// ----- sv/cvno_if.sv -----
// Valid/ready channel interfaces for the input items and the result items.
// Depends on cvno_pkg for the field widths.
`timescale 1ns / 1ps

interface cvno_in_if;
    logic                          valid;
    logic                          ready;
    logic [cvno_pkg::FUNC_W-1:0]   func;
    logic [cvno_pkg::SEL_W-1:0]    octave_sel;
    logic [cvno_pkg::COORD_W-1:0]  coord_x;
    logic [cvno_pkg::COORD_W-1:0]  coord_y;
    logic [cvno_pkg::TEXEL_W-1:0]  texel_value;

    modport source (output valid, func, octave_sel, coord_x, coord_y, texel_value,
                    input ready);
    modport sink   (input valid, func, octave_sel, coord_x, coord_y, texel_value,
                    output ready);
endinterface

interface cvno_out_if;
    logic                          valid;
    logic                          ready;
    logic [cvno_pkg::VALUE_W-1:0]  cloud_value;

    modport source (output valid, cloud_value, input ready);
    modport sink   (input valid, cloud_value, output ready);
endinterface

// ----- sv/cloud_value_noise_octaves.sv -----
// Cloud value noise over NUM_OCTAVES byte grids; depends on cvno_pkg and cvno_if.
// A write beat stores its texel in the cycle it is accepted and the block is ready again at once.
// A query reads one octave per cycle from four parity banks, then drains, offsets, multiplies and divides;
// the result is loaded once the result register is free, and the next beat is taken after that.
// The result register lets the next beat in while the previous result is still waiting.
// Reset clears the sequencer and result valid flag and loads register defaults; grids are not cleared.
`timescale 1ns / 1ps

module cloud_value_noise_octaves #(
    parameter int NUM_OCTAVES = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    cvno_in_if.sink                         in_ch,
    cvno_out_if.source                      out_ch,
    input  logic                            cfg_wr_en,
    input  logic [cvno_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cvno_pkg::CFG_W-1:0]      cfg_data
);

    localparam int OCT_W      = (NUM_OCTAVES > 1) ? $clog2(NUM_OCTAVES) : 1;
    localparam int SP_W       = NUM_OCTAVES;
    localparam int HALF_W     = cvno_pkg::TEX_IDX_W - 1;
    localparam int BANK_DEPTH = NUM_OCTAVES << (2 * HALF_W);
    localparam int BANK_AW    = $clog2(BANK_DEPTH);
    localparam int H_W        = SP_W + cvno_pkg::TEXEL_W;
    localparam int V_W        = 2 * SP_W + cvno_pkg::TEXEL_W;
    localparam int TW         = cvno_pkg::TEX_IDX_W;
    localparam int CW         = cvno_pkg::COORD_W;
    localparam int MW         = cvno_pkg::PROD_W + cvno_pkg::RECIP_W;
    localparam logic [OCT_W-1:0] LAST_OCT = OCT_W'(NUM_OCTAVES - 1);

    // Four banks, one per (row parity, column parity), so the four corners
    // of a bilinear cell are read in one cycle.
    logic [cvno_pkg::TEXEL_W-1:0] bank_mem [4][BANK_DEPTH];

    cvno_pkg::cvno_state_t state_reg, state_next;
    logic [OCT_W-1:0] oct_reg, oct_next;
    logic [CW-1:0]    x_reg, y_reg;

    logic [cvno_pkg::CFG_W-1:0] offset_reg, threshold_reg, floor_reg;

    logic in_beat;
    logic wr_en;
    logic [1:0] wr_bank;
    logic [BANK_AW-1:0] wr_addr;

    logic rd_en;
    logic [OCT_W-1:0] rd_sh;
    logic [CW-1:0] rd_cx, rd_cy;
    logic [TW-1:0] col0, col1, row0, row1, col_s, row_s;
    logic [BANK_AW-1:0] rd_addr [4];

    logic rd_vld_reg;
    logic [OCT_W-1:0] rd_oct_reg;
    logic rd_r0p_reg, rd_c0p_reg;
    logic [cvno_pkg::TEXEL_W-1:0] rd_data_reg [4];

    logic [OCT_W-1:0] h_sh;
    logic [CW-1:0] h_mask;
    logic [SP_W-1:0] h_sp, h_fx, h_wl;
    logic [cvno_pkg::TEXEL_W-1:0] t00, t01, t10, t11;
    logic [H_W-1:0] top_next, bot_next;

    logic h_vld_reg;
    logic [OCT_W-1:0] h_oct_reg;
    logic [H_W-1:0] top_reg, bot_reg;

    logic [OCT_W-1:0] v_sh;
    logic [CW-1:0] v_mask;
    logic [SP_W-1:0] v_sp, v_fy, v_wl;
    logic [V_W-1:0] v_sum;
    logic [cvno_pkg::TEXEL_W-1:0] contrib;
    logic [cvno_pkg::SUM_W-1:0] acc_reg;

    logic [cvno_pkg::SUM_W-1:0] s_next, thin_next, s_reg, thin_reg;
    logic is_thin_reg;
    logic [cvno_pkg::PROD_W-1:0] prod_reg;
    logic [MW-1:0] recip_prod;
    logic [cvno_pkg::QUO_W-1:0] quo_reg;
    logic [cvno_pkg::QUO_W-1:0] shaped;
    logic [cvno_pkg::VALUE_W-1:0] result;

    logic out_load;
    logic out_valid_reg;
    logic [cvno_pkg::VALUE_W-1:0] out_data_reg;

    // Handshake
    assign in_ch.ready        = (state_reg == cvno_pkg::ST_IDLE);
    assign in_beat            = in_ch.valid && in_ch.ready;
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.cloud_value = out_data_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= cvno_pkg::OFFSET_RST;
            threshold_reg <= cvno_pkg::THRESHOLD_RST;
            floor_reg     <= cvno_pkg::FLOOR_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                cvno_pkg::CFG_IDX_OFFSET:    offset_reg    <= cfg_data;
                cvno_pkg::CFG_IDX_THRESHOLD: threshold_reg <= cfg_data;
                cvno_pkg::CFG_IDX_FLOOR:     floor_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Texel write straight from the accepted beat; column and row wrap.
    assign wr_en   = in_beat && (in_ch.func == cvno_pkg::FUNC_WRITE) &&
                     (int'(in_ch.octave_sel) < NUM_OCTAVES);
    assign wr_bank = {in_ch.coord_y[0], in_ch.coord_x[0]};
    assign wr_addr = BANK_AW'({OCT_W'(in_ch.octave_sel),
                               in_ch.coord_y[TW-1:1], in_ch.coord_x[TW-1:1]});

    // Read addresses: lattice cell of the current octave, split by parity
    assign rd_en = (state_reg == cvno_pkg::ST_READ);
    always_comb
    begin
        rd_sh = LAST_OCT - oct_reg;
        rd_cx = x_reg >> rd_sh;
        rd_cy = y_reg >> rd_sh;
        col0  = rd_cx[TW-1:0];
        row0  = rd_cy[TW-1:0];
        col1  = col0 + TW'(1);
        row1  = row0 + TW'(1);
        col_s = col0;
        row_s = row0;
        for (int b = 0; b < 4; b++)
        begin
            row_s = (row0[0] == b[1]) ? row0 : row1;
            col_s = (col0[0] == b[0]) ? col0 : col1;
            rd_addr[b] = BANK_AW'({oct_reg, row_s[TW-1:1], col_s[TW-1:1]});
        end
    end

    // Bank memories: one write and one registered read per bank and cycle
    always_ff @(posedge clk)
    begin
        for (int b = 0; b < 4; b++)
        begin
            if (wr_en && (wr_bank == 2'(b)))
            begin
                bank_mem[b][wr_addr] <= in_ch.texel_value;
            end
            if (rd_en)
            begin
                rd_data_reg[b] <= bank_mem[b][rd_addr[b]];
            end
        end
    end

    // Horizontal interpolation of the returned corners
    always_comb
    begin
        h_sh   = LAST_OCT - rd_oct_reg;
        h_sp   = SP_W'(1) << h_sh;
        h_mask = (CW'(1) << h_sh) - CW'(1);
        h_fx   = SP_W'(x_reg & h_mask);
        h_wl   = h_sp - h_fx;
        t00    = rd_data_reg[{rd_r0p_reg,  rd_c0p_reg}] >> rd_oct_reg;
        t01    = rd_data_reg[{rd_r0p_reg, ~rd_c0p_reg}] >> rd_oct_reg;
        t10    = rd_data_reg[{~rd_r0p_reg,  rd_c0p_reg}] >> rd_oct_reg;
        t11    = rd_data_reg[{~rd_r0p_reg, ~rd_c0p_reg}] >> rd_oct_reg;
        top_next = H_W'(h_wl) * H_W'(t00) + H_W'(h_fx) * H_W'(t01);
        bot_next = H_W'(h_wl) * H_W'(t10) + H_W'(h_fx) * H_W'(t11);
    end

    // Vertical interpolation and the division by the cell area
    always_comb
    begin
        v_sh    = LAST_OCT - h_oct_reg;
        v_sp    = SP_W'(1) << v_sh;
        v_mask  = (CW'(1) << v_sh) - CW'(1);
        v_fy    = SP_W'(y_reg & v_mask);
        v_wl    = v_sp - v_fy;
        v_sum   = V_W'(top_reg) * V_W'(v_wl) + V_W'(bot_reg) * V_W'(v_fy);
        contrib = cvno_pkg::TEXEL_W'(v_sum >> {v_sh, 1'b0});
    end

    // Octave pipeline registers and the sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
            h_vld_reg  <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= rd_en;
            h_vld_reg  <= rd_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            x_reg   <= in_ch.coord_x;
            y_reg   <= in_ch.coord_y;
            acc_reg <= '0;
        end
        else if (h_vld_reg)
        begin
            acc_reg <= acc_reg + cvno_pkg::SUM_W'(contrib);
        end
        rd_oct_reg <= oct_reg;
        rd_r0p_reg <= row0[0];
        rd_c0p_reg <= col0[0];
        h_oct_reg  <= rd_oct_reg;
        top_reg    <= top_next;
        bot_reg    <= bot_next;
    end

    // Offset, threshold test, thin-cloud shaping and saturation
    always_comb
    begin
        s_next    = (acc_reg > offset_reg) ? acc_reg - offset_reg : '0;
        thin_next = (s_next > floor_reg) ? s_next - floor_reg : '0;
        recip_prod = MW'(prod_reg) * MW'(cvno_pkg::THIN_RECIP);
        shaped    = is_thin_reg ? quo_reg : cvno_pkg::QUO_W'(s_reg);
        result    = (shaped > cvno_pkg::QUO_W'(cvno_pkg::SAT_MAX)) ?
                    cvno_pkg::SAT_MAX : shaped[cvno_pkg::VALUE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == cvno_pkg::ST_OFFS)
        begin
            s_reg       <= s_next;
            thin_reg    <= thin_next;
            is_thin_reg <= (s_next < threshold_reg);
        end
        if (state_reg == cvno_pkg::ST_MUL)
        begin
            prod_reg <= cvno_pkg::PROD_W'(thin_reg) * cvno_pkg::PROD_W'(s_reg);
        end
        if (state_reg == cvno_pkg::ST_DIV)
        begin
            quo_reg <= recip_prod[cvno_pkg::THIN_SHIFT +: cvno_pkg::QUO_W];
        end
    end

    // Sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cvno_pkg::ST_IDLE;
            oct_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            oct_reg   <= oct_next;
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        oct_next   = oct_reg;
        out_load   = 1'b0;
        case (state_reg)
            cvno_pkg::ST_IDLE:
            begin
                oct_next = '0;
                if (in_beat && (in_ch.func == cvno_pkg::FUNC_QUERY))
                begin
                    state_next = cvno_pkg::ST_READ;
                end
            end
            cvno_pkg::ST_READ:
            begin
                oct_next = oct_reg + OCT_W'(1);
                if (oct_reg == LAST_OCT)
                begin
                    state_next = cvno_pkg::ST_DRAIN;
                end
            end
            cvno_pkg::ST_DRAIN:
            begin
                // The last octave is added at the end of this cycle.
                if (h_vld_reg && !rd_vld_reg)
                begin
                    state_next = cvno_pkg::ST_OFFS;
                end
            end
            cvno_pkg::ST_OFFS: state_next = cvno_pkg::ST_MUL;
            cvno_pkg::ST_MUL:  state_next = cvno_pkg::ST_DIV;
            cvno_pkg::ST_DIV:  state_next = cvno_pkg::ST_OUT;
            cvno_pkg::ST_OUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_load   = 1'b1;
                    state_next = cvno_pkg::ST_IDLE;
                end
            end
            default: state_next = cvno_pkg::ST_IDLE;
        endcase
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= result;
        end
    end

endmodule

// ----- sv/cvno_checker.sv -----
// Port-level checks for the cloud value noise block, attached by bind.
// Depends on cvno_pkg and on the ports of cloud_value_noise_octaves.
`timescale 1ns / 1ps

module cvno_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic [cvno_pkg::FUNC_W-1:0]    in_func,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [cvno_pkg::VALUE_W-1:0]   out_value
);

    // A query beat keeps the block busy in the following cycle.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (in_func == cvno_pkg::FUNC_QUERY)) |=> !in_ready)
        else $error("input ready right after a query beat");

    // A write beat leaves the block ready in the following cycle.
    a_write_single: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (in_func == cvno_pkg::FUNC_WRITE)) |=> in_ready)
        else $error("block busy after a write beat");

    // A new result appears only as the query ends, so the input is open again.
    a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result shown while the query is still running");

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its value.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(out_value))
        else $error("result changed while stalled");

endmodule

bind cloud_value_noise_octaves cvno_checker u_cvno_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_func   (in_ch.func),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_value (out_ch.cloud_value)
);

// ----- test/tb_cloud_value_noise_octaves.sv -----
// Testbench for cloud_value_noise_octaves: loads the texels that the queries reach, then sends
// query and texel beats and compares each cloud density with a scoreboard that computes it.
// Depends on cvno_pkg, cvno_if and the block itself.
`timescale 1ns / 1ps

// Expected-density scoreboard: keeps a copy of the grids and registers.
class cloud_scoreboard;
    localparam int OCTAVES = 4;
    bit [7:0] grid [OCTAVES][cvno_pkg::OCT_SIZE][cvno_pkg::OCT_SIZE];
    bit [cvno_pkg::CFG_W-1:0] offset_lvl;
    bit [cvno_pkg::CFG_W-1:0] threshold_lvl;
    bit [cvno_pkg::CFG_W-1:0] floor_lvl;
    bit [cvno_pkg::VALUE_W-1:0] pending_density [$];
    int errors;

    function void reset_state();
        offset_lvl    = cvno_pkg::OFFSET_RST;
        threshold_lvl = cvno_pkg::THRESHOLD_RST;
        floor_lvl     = cvno_pkg::FLOOR_RST;
        pending_density.delete();
        errors = 0;
    endfunction

    // An index that names no register leaves everything as it is.
    function void set_register(bit [cvno_pkg::CFG_IDX_W-1:0] idx,
                               bit [cvno_pkg::CFG_W-1:0] val);
        case (idx)
            cvno_pkg::CFG_IDX_OFFSET:    offset_lvl    = val;
            cvno_pkg::CFG_IDX_THRESHOLD: threshold_lvl = val;
            cvno_pkg::CFG_IDX_FLOOR:     floor_lvl     = val;
            default: ;
        endcase
    endfunction

    // Octave sum with bilinear interpolation, then offset, thin-cloud shaping and clamp.
    function bit [cvno_pkg::VALUE_W-1:0] cloud_density(bit [15:0] x, bit [15:0] y);
        int unsigned sum, sp, cx, cy, fx, fy, cx1, cy1;
        int unsigned t00, t10, t01, t11, top, bot, thin;
        sum = 0;
        for (int i = 0; i < OCTAVES; i++)
        begin
            sp  = 1 << (OCTAVES - 1 - i);
            cx  = x / sp;
            cy  = y / sp;
            fx  = x % sp;
            fy  = y % sp;
            cx1 = (cx + 1) % cvno_pkg::OCT_SIZE;
            cy1 = (cy + 1) % cvno_pkg::OCT_SIZE;
            cx  = cx % cvno_pkg::OCT_SIZE;
            cy  = cy % cvno_pkg::OCT_SIZE;
            t00 = grid[i][cy][cx] >> i;
            t10 = grid[i][cy][cx1] >> i;
            t01 = grid[i][cy1][cx] >> i;
            t11 = grid[i][cy1][cx1] >> i;
            top = (sp - fx) * t00 + fx * t10;
            bot = (sp - fx) * t01 + fx * t11;
            sum += (top * (sp - fy) + bot * fy) / (sp * sp);
        end
        sum = (sum > offset_lvl) ? sum - offset_lvl : 0;
        if (sum < threshold_lvl)
        begin
            thin = (sum > floor_lvl) ? sum - floor_lvl : 0;
            sum  = thin * sum / cvno_pkg::THIN_DIV;
        end
        if (sum > cvno_pkg::SAT_MAX)
            sum = cvno_pkg::SAT_MAX;
        return sum[cvno_pkg::VALUE_W-1:0];
    endfunction

    // Accepted input beat: texel writes update the grid, queries queue a density.
    function void record_input(bit [cvno_pkg::FUNC_W-1:0] func, bit [1:0] sel,
                               bit [15:0] x, bit [15:0] y, bit [7:0] texel);
        if (func == cvno_pkg::FUNC_WRITE)
        begin
            if (sel < OCTAVES)
                grid[sel][y % cvno_pkg::OCT_SIZE][x % cvno_pkg::OCT_SIZE] = texel;
        end
        else
            pending_density.push_back(cloud_density(x, y));
    endfunction

    // Accepted result beat: compare with the oldest queued density.
    function void check_density(bit [cvno_pkg::VALUE_W-1:0] got);
        bit [cvno_pkg::VALUE_W-1:0] want;
        if (pending_density.size() == 0)
        begin
            errors++;
            $display("%0t: result beat with nothing expected, actual cloud_value %0d",
                     $time, got);
        end
        else
        begin
            want = pending_density.pop_front();
            if (want !== got)
            begin
                errors++;
                $display("%0t: cloud_value mismatch, expected %0d, actual %0d",
                         $time, want, got);
            end
        end
    endfunction
endclass

module tb_cloud_value_noise_octaves;

    localparam logic [cvno_pkg::CFG_IDX_W-1:0] CFG_IDX_NONE = 2'd3;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 16;
    localparam int PHASE_ITEMS = 100;
    localparam int NUM_PHASES  = 8;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [cvno_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [cvno_pkg::CFG_W-1:0] cfg_data;

    cvno_in_if  in_ch ();
    cvno_out_if out_ch ();

    cloud_scoreboard sb;

    // Idling controls: idle_on is shared by the sender and the receiver, long_hold_req is the receiver's.
    bit idle_on;
    bit long_hold_req;

    cloud_value_noise_octaves dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Run limit, well above the slowest correct run.
    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    // Beat monitor on both channels; results are checked before the new input is noted.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_density(out_ch.cloud_value);
        if (rst_n && in_ch.valid && in_ch.ready)
            sb.record_input(in_ch.func, in_ch.octave_sel, in_ch.coord_x, in_ch.coord_y,
                            in_ch.texel_value);
    end

    // Receiver: random stall bursts, and one long hold-off when asked.
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                stall_left = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 16);
            if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Offer one input beat and hold it until accepted; entered and left at a falling edge.
    task automatic send_beat(bit [cvno_pkg::FUNC_W-1:0] func, bit [1:0] sel, bit [15:0] x,
                             bit [15:0] y, bit [7:0] texel);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.func        <= func;
        in_ch.octave_sel  <= sel;
        in_ch.coord_x     <= x;
        in_ch.coord_y     <= y;
        in_ch.texel_value <= texel;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
    endtask

    // Register write, one beat per cycle; the caller lowers the write enable afterwards.
    task automatic write_register(bit [cvno_pkg::CFG_IDX_W-1:0] idx,
                                  bit [cvno_pkg::CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.set_register(idx, val);
        @(negedge clk);
    endtask

    // Wait for every queued density, then let the pipeline drain.
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (sb.pending_density.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Texel values lean on the extremes.
    function automatic bit [7:0] pick_texel();
        case ($urandom_range(0, 3))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Lattice index k wrapped into the grid, with random high bits that wrap away.
    function automatic bit [15:0] wrap_coord(int k);
        return 16'((k + cvno_pkg::OCT_SIZE) % cvno_pkg::OCT_SIZE
                   + cvno_pkg::OCT_SIZE * $urandom_range(0, 2047));
    endfunction

    // Query coordinates keep their low byte within 8 of zero, wrapped, so every texel a
    // query reaches has been loaded; the high byte is free. Near zero, near the top, and
    // on lattice points.
    function automatic bit [15:0] pick_coord();
        bit [7:0] hi;
        bit [7:0] lo;
        hi = 8'($urandom_range(0, 255));
        lo = 8'd248 + 8'($urandom_range(0, 15));
        case ($urandom_range(0, 9))
            0, 1, 2, 3: ;
            4, 5:       hi = 8'h00;
            6:          hi = 8'hFF;
            7, 8:       lo = lo & 8'hF8;
            default:    lo = lo & 8'hFC;
        endcase
        return {hi, lo};
    endfunction

    // Random mix of texel writes (full coordinate range, so they wrap) and queries.
    task automatic run_random(int count);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 2) == 0)
                send_beat(cvno_pkg::FUNC_WRITE, 2'($urandom_range(0, 3)),
                          16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                          pick_texel());
            else
                send_beat(cvno_pkg::FUNC_QUERY, 2'($urandom_range(0, 3)), pick_coord(),
                          pick_coord(), 8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        bit [cvno_pkg::CFG_W-1:0] offs [NUM_PHASES];
        bit [cvno_pkg::CFG_W-1:0] thrs [NUM_PHASES];
        bit [cvno_pkg::CFG_W-1:0] flrs [NUM_PHASES];

        sb = new();
        sb.reset_state();
        idle_on = 1'b1;
        long_hold_req = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.func = cvno_pkg::FUNC_WRITE;
        in_ch.octave_sel = '0;
        in_ch.coord_x = '0;
        in_ch.coord_y = '0;
        in_ch.texel_value = '0;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Load the texels around the grid origin that queries reach: octave oct spans
        // 1 << oct lattice steps on either side of zero. High coordinate bits wrap away.
        for (int oct = 0; oct < 4; oct++)
            for (int dr = -(1 << oct); dr <= (1 << oct); dr++)
                for (int dc = -(1 << oct); dc <= (1 << oct); dc++)
                    send_beat(cvno_pkg::FUNC_WRITE, 2'(oct), wrap_coord(dc),
                              wrap_coord(dr), pick_texel());

        // Directed: coordinate extremes under the reset settings.
        send_beat(cvno_pkg::FUNC_QUERY, 2'd0, 16'd0, 16'd0, 8'd0);
        send_beat(cvno_pkg::FUNC_QUERY, 2'd3, 16'hFFFF, 16'hFFFF, 8'hFF);
        send_beat(cvno_pkg::FUNC_QUERY, 2'd1, 16'hFFFF, 16'd0, 8'h55);
        send_beat(cvno_pkg::FUNC_QUERY, 2'd2, 16'd0, 16'hFFFF, 8'hAA);
        send_beat(cvno_pkg::FUNC_QUERY, 2'd0, 16'd7, 16'd7, 8'd0);
        send_beat(cvno_pkg::FUNC_QUERY, 2'd0, 16'hFFF8, 16'hFFF8, 8'd0);
        send_beat(cvno_pkg::FUNC_QUERY, 2'd0, 16'd1, 16'd0, 8'd0);

        // Directed: full texels at the origin of every octave saturate the result.
        for (int oct = 0; oct < 4; oct++)
            send_beat(cvno_pkg::FUNC_WRITE, 2'(oct), 16'd0, 16'd0, 8'd255);
        send_beat(cvno_pkg::FUNC_QUERY, 2'd0, 16'd0, 16'd0, 8'd0);

        // Directed: empty texels at the origin give a thin cloud.
        for (int oct = 0; oct < 4; oct++)
            send_beat(cvno_pkg::FUNC_WRITE, 2'(oct), 16'hFFE0, 16'h0020, 8'd0);
        send_beat(cvno_pkg::FUNC_QUERY, 2'd0, 16'd0, 16'd0, 8'd0);

        // Directed: a write with the largest coordinates lands on the last texel.
        send_beat(cvno_pkg::FUNC_WRITE, 2'd3, 16'hFFFF, 16'hFFFF, 8'd255);
        send_beat(cvno_pkg::FUNC_QUERY, 2'd3, 16'h00FF, 16'h00FF, 8'd0);
        send_beat(cvno_pkg::FUNC_QUERY, 2'd3, 16'hFFFF, 16'hFFFF, 8'd0);
        settle();

        // Register settings per phase: the extremes and the reset values first, then random ones.
        offs[0] = 9'd0;   thrs[0] = 9'd0;   flrs[0] = 9'd0;
        offs[1] = 9'd511; thrs[1] = 9'd511; flrs[1] = 9'd511;
        offs[2] = cvno_pkg::OFFSET_RST;
        thrs[2] = cvno_pkg::THRESHOLD_RST;
        flrs[2] = cvno_pkg::FLOOR_RST;
        offs[3] = 9'd0;   thrs[3] = 9'd511; flrs[3] = 9'd0;
        offs[4] = 9'd0;   thrs[4] = 9'd511; flrs[4] = 9'd511;
        offs[5] = 9'd511; thrs[5] = 9'd0;   flrs[5] = 9'd0;
        for (int p = 6; p < NUM_PHASES; p++)
        begin
            offs[p] = 9'($urandom_range(0, 120));
            thrs[p] = 9'($urandom_range(0, 511));
            flrs[p] = 9'($urandom_range(0, 400));
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_register(cvno_pkg::CFG_IDX_OFFSET, offs[p]);
            write_register(cvno_pkg::CFG_IDX_THRESHOLD, thrs[p]);
            write_register(cvno_pkg::CFG_IDX_FLOOR, flrs[p]);
            // A write to the unused index must leave the registers alone.
            if (p == 4)
                write_register(CFG_IDX_NONE, 9'($urandom_range(0, 511)));
            cfg_wr_en <= 1'b0;
            @(negedge clk);

            // Idling pattern: bursts in most phases, none in phases 2 and 5 and in the last one.
            idle_on = (p == NUM_PHASES - 1) ? 1'b0 : (p % 3 != 2);
            if (p == 3)
                long_hold_req = 1'b1;
            run_random(PHASE_ITEMS);
            settle();
        end

        if (sb.errors == 0 && sb.pending_density.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
